FILE: rtl/button_gesture_decoder_unit_assert.svh
// Assertion macros of the button gesture decoder RTL.
`ifndef BUTTON_GESTURE_DECODER_UNIT_ASSERT_SVH
`define BUTTON_GESTURE_DECODER_UNIT_ASSERT_SVH

// Condition must hold in the same cycle as the trigger.
`define BGD_ASSERT_SAME(label, clk, rst_n, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
		else $error(msg);

// Condition must hold in the cycle after the trigger.
`define BGD_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

FILE: rtl/bgd_pkg.sv
// Types and constants of the button gesture decoder.
`default_nettype none

package bgd_pkg;

	localparam int unsigned CFG_W       = 16;
	localparam int unsigned CFG_ADDR_W  = 2;
	localparam int unsigned IN_TDATA_W  = 40;
	localparam int unsigned OUT_TDATA_W = 8;
	localparam int unsigned NOW_W       = 32;

	// Configuration register indexes.
	localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_HOLD     = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_WINDOW   = 2'd2;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd30;
	localparam logic [CFG_W-1:0] HOLD_RST     = 16'd3000;
	localparam logic [CFG_W-1:0] WINDOW_RST   = 16'd400;

	typedef enum logic [1:0] {
		GEST_NONE   = 2'd0,
		GEST_TAP    = 2'd1,
		GEST_DOUBLE = 2'd2,
		GEST_HOLD   = 2'd3
	} gesture_t;

	typedef struct packed {
		logic [CFG_W-1:0] debounce_ms;
		logic [CFG_W-1:0] hold_ms;
		logic [CFG_W-1:0] double_window_ms;
	} cfg_t;

	typedef struct packed {
		logic stable_level;
		logic hold_reported;
		logic tap_pending;
	} core_status_t;

endpackage

`default_nettype wire

FILE: rtl/bgd_cfg.sv
// Configuration register file of the button gesture decoder.
`default_nettype none

module bgd_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [bgd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  wire logic [bgd_pkg::CFG_W-1:0]       cfg_wdata,
	output bgd_pkg::cfg_t                        cfg
);

	bgd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms      <= bgd_pkg::DEBOUNCE_RST;
			cfg_q.hold_ms          <= bgd_pkg::HOLD_RST;
			cfg_q.double_window_ms <= bgd_pkg::WINDOW_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				bgd_pkg::REG_DEBOUNCE: cfg_q.debounce_ms      <= cfg_wdata;
				bgd_pkg::REG_HOLD:     cfg_q.hold_ms          <= cfg_wdata;
				bgd_pkg::REG_WINDOW:   cfg_q.double_window_ms <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/bgd_core.sv
// Debounce and gesture decision logic with the decoder's state registers.
`default_nettype none

module bgd_core #(
	parameter int unsigned TIMESTAMP_BITS = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire bgd_pkg::cfg_t              cfg,
	input  wire logic                       step_en,
	input  wire logic                       pressed,
	input  wire logic [TIMESTAMP_BITS-1:0]  now,
	output bgd_pkg::gesture_t               code,
	output bgd_pkg::core_status_t           status
);

	logic                      raw_level_q;
	logic                      stable_level_q;
	logic [TIMESTAMP_BITS-1:0] last_change_q;
	logic [TIMESTAMP_BITS-1:0] press_start_q;
	logic [TIMESTAMP_BITS-1:0] last_release_q;
	logic                      hold_reported_q;
	logic                      tap_pending_q;

	logic [TIMESTAMP_BITS-1:0] last_change_d;
	logic [TIMESTAMP_BITS-1:0] press_start_d;
	logic [TIMESTAMP_BITS-1:0] last_release_d;
	logic                      stable_level_d;
	logic                      hold_reported_d;
	logic                      tap_pending_d;
	logic                      accept_change;
	logic                      double_hit;
	logic [TIMESTAMP_BITS-1:0] since_change;
	logic [TIMESTAMP_BITS-1:0] since_press;
	logic [TIMESTAMP_BITS-1:0] since_release;

	always_comb begin
		last_change_d   = (pressed != raw_level_q) ? now : last_change_q;
		since_change    = now - last_change_d;
		accept_change   = (since_change >= TIMESTAMP_BITS'(cfg.debounce_ms))
			&& (pressed != stable_level_q);

		stable_level_d  = accept_change ? pressed : stable_level_q;
		press_start_d   = press_start_q;
		last_release_d  = last_release_q;
		hold_reported_d = hold_reported_q;
		tap_pending_d   = tap_pending_q;
		double_hit      = 1'b0;

		if (accept_change && pressed) begin
			press_start_d   = now;
			hold_reported_d = 1'b0;
		end else if (accept_change && !hold_reported_q) begin
			// A debounced release that ends a short press is a tap.
			last_release_d = now;
			double_hit     = tap_pending_q;
			tap_pending_d  = !tap_pending_q;
		end

		since_press   = now - press_start_d;
		since_release = now - last_release_d;
		code          = bgd_pkg::GEST_NONE;

		if (double_hit) begin
			code = bgd_pkg::GEST_DOUBLE;
		end else if (stable_level_d && !hold_reported_d
			&& since_press >= TIMESTAMP_BITS'(cfg.hold_ms)) begin
			hold_reported_d = 1'b1;
			tap_pending_d   = 1'b0;
			code            = bgd_pkg::GEST_HOLD;
		end else if (tap_pending_d && !stable_level_d
			&& since_release >= TIMESTAMP_BITS'(cfg.double_window_ms)) begin
			tap_pending_d = 1'b0;
			code          = bgd_pkg::GEST_TAP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_level_q     <= 1'b0;
			stable_level_q  <= 1'b0;
			last_change_q   <= '0;
			press_start_q   <= '0;
			last_release_q  <= '0;
			hold_reported_q <= 1'b0;
			tap_pending_q   <= 1'b0;
		end else if (step_en) begin
			raw_level_q     <= pressed;
			stable_level_q  <= stable_level_d;
			last_change_q   <= last_change_d;
			press_start_q   <= press_start_d;
			last_release_q  <= last_release_d;
			hold_reported_q <= hold_reported_d;
			tap_pending_q   <= tap_pending_d;
		end
	end

	assign status.stable_level  = stable_level_q;
	assign status.hold_reported = hold_reported_q;
	assign status.tap_pending   = tap_pending_q;

endmodule

`default_nettype wire

FILE: rtl/button_gesture_decoder_unit.sv
// Button gesture decoder: debounces timestamped button samples into gestures.
//
// Each sample transfer on the slave stream gives exactly one gesture code on the
// master stream (none, single tap, double tap or hold). One sample is taken per
// clock cycle when the output is not stalled. A sample is captured in the input
// register, runs through the debounce and gesture logic and lands in the result
// register, from which its result is offered on the master stream. The input
// register also absorbs one sample while a result waits to be taken.
// Configuration writes take effect on the next sample and are to be made only
// while no sample is in flight. Timestamp differences wrap modulo
// 2^TIMESTAMP_BITS.
`default_nettype none

module button_gesture_decoder_unit #(
	parameter int unsigned TIMESTAMP_BITS = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [bgd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  wire logic [bgd_pkg::CFG_W-1:0]         cfg_wdata,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// [0] pressed, [32:1] now_ms, [39:33] zero
	input  wire logic [bgd_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// [1:0] gesture_code, [7:2] zero
	output logic [bgd_pkg::OUT_TDATA_W-1:0]        m_tdata
);

	bgd_pkg::cfg_t          cfg;
	bgd_pkg::gesture_t      code;
	bgd_pkg::core_status_t  status;

	logic                      valid_s1;
	logic                      pressed_s1;
	logic [TIMESTAMP_BITS-1:0] now_s1;
	logic                      out_valid_q;
	bgd_pkg::gesture_t         out_code_q;
	logic                      advance;
	logic                      step_en;

	assign advance  = !out_valid_q || m_tready;
	assign step_en  = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	bgd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	bgd_core #(
		.TIMESTAMP_BITS (TIMESTAMP_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.step_en (step_en),
		.pressed (pressed_s1),
		.now     (now_s1),
		.code    (code),
		.status  (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			pressed_s1 <= s_tdata[0];
			now_s1     <= TIMESTAMP_BITS'(s_tdata[bgd_pkg::NOW_W:1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			out_code_q <= code;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(bgd_pkg::OUT_TDATA_W - 2)'(0), out_code_q};

	`include "button_gesture_decoder_unit_assert.svh"

	`BGD_ASSERT_SAME(a_stall_blocks_input, clk, arst_n, valid_s1 && out_valid_q && !m_tready, !s_tready, "input taken while both stages are full")
	`BGD_ASSERT_SAME(a_hold_excludes_tap, clk, arst_n, status.hold_reported, !status.tap_pending, "tap pending after a hold")
	`BGD_ASSERT_NEXT(a_double_clears_tap, clk, arst_n, step_en && code == bgd_pkg::GEST_DOUBLE, !status.tap_pending && m_tvalid, "double tap left a tap pending")

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for the button gesture decoder unit.
`timescale 1ns / 100ps

module testbench;

	localparam logic [bgd_pkg::CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;
	localparam int unsigned PHASE_ITEMS = 120;
	localparam int unsigned SQUEEZE_CYCLES = 300;

	typedef struct packed {
		bit        pressed;
		bit [31:0] now_ms;
	} sample_t;

	typedef enum int {
		SHAPE_TAP,
		SHAPE_DOUBLE,
		SHAPE_HOLD,
		SHAPE_NOISE
	} shape_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [bgd_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [bgd_pkg::CFG_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [bgd_pkg::IN_TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [bgd_pkg::OUT_TDATA_W-1:0] m_tdata;

	button_gesture_decoder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Configuration and state of the gesture predictor.
	logic [bgd_pkg::CFG_W-1:0] debounce_cfg = bgd_pkg::DEBOUNCE_RST;
	logic [bgd_pkg::CFG_W-1:0] hold_cfg     = bgd_pkg::HOLD_RST;
	logic [bgd_pkg::CFG_W-1:0] window_cfg   = bgd_pkg::WINDOW_RST;
	bit        raw_lvl;
	bit        stable_lvl;
	bit [31:0] change_ts;
	bit [31:0] press_ts;
	bit [31:0] release_ts;
	bit        hold_seen;
	bit        tap_waiting;

	sample_t           pending_samples[$];
	bgd_pkg::gesture_t expected_gestures[$];
	sample_t           offered;
	bgd_pkg::gesture_t want;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	bit          squeeze = 1'b0;
	bit          rx_hold = 1'b0;
	int unsigned errors = 0;
	int unsigned samples_sent = 0;
	int unsigned gesture_seen[4] = '{0, 0, 0, 0};
	bit [31:0]   t_now;

	// Next gesture code for one sample; all time differences wrap at 32 bits.
	function automatic bgd_pkg::gesture_t decode_sample(input bit pressed, input bit [31:0] now);
		bit [31:0] since_change;
		if (pressed != raw_lvl) begin
			raw_lvl = pressed;
			change_ts = now;
		end
		since_change = now - change_ts;
		if (since_change >= {16'd0, debounce_cfg} && pressed != stable_lvl) begin
			stable_lvl = pressed;
			if (stable_lvl) begin
				press_ts = now;
				hold_seen = 1'b0;
			end else if (!hold_seen) begin
				release_ts = now;
				if (tap_waiting) begin
					tap_waiting = 1'b0;
					return bgd_pkg::GEST_DOUBLE;
				end
				tap_waiting = 1'b1;
			end
		end
		if (stable_lvl && !hold_seen && (now - press_ts) >= {16'd0, hold_cfg}) begin
			hold_seen = 1'b1;
			tap_waiting = 1'b0;
			return bgd_pkg::GEST_HOLD;
		end
		if (tap_waiting && !stable_lvl && (now - release_ts) >= {16'd0, window_cfg}) begin
			tap_waiting = 1'b0;
			return bgd_pkg::GEST_TAP;
		end
		return bgd_pkg::GEST_NONE;
	endfunction

	// Sample driver: the expectation is formed at the transfer itself.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				expected_gestures.push_back(decode_sample(offered.pressed, offered.now_ms));
			if (!s_tvalid || s_tready) begin
				if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					offered = pending_samples.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {7'd0, offered.now_ms, offered.pressed};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_gestures.size() == 0) begin
					errors++;
					$display("%0t: result with nothing expected: expected none, got %h",
						$time, m_tdata);
				end else begin
					want = expected_gestures.pop_front();
					if (m_tdata !== {6'd0, want}) begin
						errors++;
						$display("%0t: gesture mismatch: expected %h (%s), got %h",
							$time, {6'd0, want}, want.name(), m_tdata);
					end
				end
				gesture_seen[m_tdata[1:0]]++;
			end
			m_tready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// One long receiver hold-off while the sender keeps offering samples.
	initial begin : long_stall
		wait (squeeze);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (SQUEEZE_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	task automatic push_sample(input bit pressed, input bit [31:0] now);
		pending_samples.push_back('{pressed, now});
		samples_sent++;
	endtask

	// A value at or right around a threshold, or anywhere up to twice it plus two.
	function automatic int unsigned near(input int unsigned x);
		case ($urandom_range(3))
			0: return x;
			1: return (x == 0) ? 0 : x - 1;
			2: return x + 1;
			default: return $urandom_range(0, 2 * x + 2);
		endcase
	endfunction

	// A span strictly shorter than a threshold (zero for a zero threshold), often just below it.
	function automatic int unsigned under(input int unsigned x);
		if (x == 0)
			return 0;
		return ($urandom_range(1) == 0) ? x - 1 : $urandom_range(0, x - 1);
	endfunction

	// Level change, a sample near the debounce point, then the level held for span.
	task automatic push_level(input bit lvl, input int unsigned span);
		int unsigned settle;
		int unsigned n;
		int unsigned i;
		settle = near(debounce_cfg);
		push_sample(lvl, t_now);
		push_sample(lvl, t_now + settle);
		n = $urandom_range(0, 2);
		for (i = 1; i <= n; i++)
			push_sample(lvl, t_now + settle + span / (n + 1) * i);
		push_sample(lvl, t_now + settle + span);
		t_now += settle + span + $urandom_range(0, 2);
	endtask

	// Contact bounce: one to three random levels, each at most half the debounce time after the last.
	task automatic push_bounce();
		int unsigned n;
		int unsigned i;
		n = $urandom_range(1, 3);
		for (i = 0; i < n; i++) begin
			t_now += $urandom_range(0, debounce_cfg / 2);
			push_sample($urandom_range(1), t_now);
		end
	endtask

	task automatic add_gesture();
		shape_t shape;
		int unsigned n;
		int unsigned i;
		int unsigned pick;
		pick = $urandom_range(99);
		shape = (pick < 28) ? SHAPE_TAP : (pick < 56) ? SHAPE_DOUBLE :
			(pick < 82) ? SHAPE_HOLD : SHAPE_NOISE;
		if ($urandom_range(2) == 0)
			push_bounce();
		case (shape)
			SHAPE_TAP: begin
				push_level(1'b1, under(hold_cfg));
				push_level(1'b0, near(window_cfg));
			end
			SHAPE_DOUBLE: begin
				push_level(1'b1, under(hold_cfg));
				if ($urandom_range(3) == 0)
					push_bounce();
				push_level(1'b0, under(window_cfg));
				push_level(1'b1, under(hold_cfg));
				push_level(1'b0, near(window_cfg));
			end
			SHAPE_HOLD: begin
				push_level(1'b1, near(hold_cfg));
				push_level(1'b0, near(window_cfg));
			end
			default: begin
				// Random levels, sometimes with a jump to an arbitrary timestamp.
				if ($urandom_range(1) == 0)
					t_now = $urandom;
				n = $urandom_range(1, 4);
				for (i = 0; i < n; i++) begin
					push_sample($urandom_range(1), ($urandom_range(3) == 0) ? $urandom : t_now);
					t_now += $urandom_range(0, 3 * debounce_cfg + 4);
				end
			end
		endcase
	endtask

	task automatic add_random_samples(input int unsigned count);
		int unsigned goal;
		goal = samples_sent + count;
		while (samples_sent < goal)
			add_gesture();
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_samples.size() != 0 || s_tvalid || expected_gestures.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_settings(input logic [bgd_pkg::CFG_W-1:0] deb,
			input logic [bgd_pkg::CFG_W-1:0] hold,
			input logic [bgd_pkg::CFG_W-1:0] win, input bit poke_unused);
		logic [bgd_pkg::CFG_ADDR_W-1:0] regs[4];
		logic [bgd_pkg::CFG_W-1:0] vals[4];
		int unsigned i;
		int unsigned last;
		regs = '{bgd_pkg::REG_DEBOUNCE, bgd_pkg::REG_HOLD, bgd_pkg::REG_WINDOW, REG_UNUSED};
		vals = '{deb, hold, win, bgd_pkg::CFG_W'($urandom)};
		last = poke_unused ? 3 : 2;
		for (i = 0; i <= last; i++) begin
			cfg_we <= 1'b1;
			cfg_addr <= regs[i];
			cfg_wdata <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		debounce_cfg = deb;
		hold_cfg = hold;
		window_cfg = win;
	endtask

	initial begin : stimulus
		logic [bgd_pkg::CFG_W-1:0] deb_set[7];
		logic [bgd_pkg::CFG_W-1:0] hold_set[7];
		logic [bgd_pkg::CFG_W-1:0] win_set[7];
		int unsigned send_set[7];
		int unsigned recv_set[7];
		int unsigned ph;
		deb_set  = '{16'd0, 16'hFFFF, 16'd5,   bgd_pkg::CFG_W'($urandom_range(100)),  16'd0,
			16'hFFFF, bgd_pkg::DEBOUNCE_RST};
		hold_set = '{16'd0, 16'hFFFF, 16'd200, bgd_pkg::CFG_W'($urandom_range(3000)), 16'hFFFF,
			16'd0, bgd_pkg::HOLD_RST};
		win_set  = '{16'd0, 16'hFFFF, 16'd50,  bgd_pkg::CFG_W'($urandom_range(500)),  16'd0,
			16'hFFFF, bgd_pkg::WINDOW_RST};
		send_set = '{74, 0, 13, 0, 0, 74, 13};
		recv_set = '{0, 74, 13, 0, 74, 0, 13};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: timestamp wrap on a press, a hold and the release after it,
		// a single tap right at the window edge, a double tap, out-of-order stamps.
		push_sample(1'b0, 32'd0);
		push_sample(1'b1, 32'hFFFF_FFF0);
		push_sample(1'b1, 32'h0000_000E);
		push_sample(1'b1, 32'h0000_0BC5);
		push_sample(1'b1, 32'h0000_0BC6);
		push_sample(1'b0, 32'd4000);
		push_sample(1'b0, 32'd4030);
		push_sample(1'b1, 32'd5000);
		push_sample(1'b1, 32'd5030);
		push_sample(1'b0, 32'd5100);
		push_sample(1'b0, 32'd5130);
		push_sample(1'b0, 32'd5529);
		push_sample(1'b0, 32'd5530);
		push_sample(1'b1, 32'd6000);
		push_sample(1'b1, 32'd6030);
		push_sample(1'b0, 32'd6100);
		push_sample(1'b0, 32'd6130);
		push_sample(1'b1, 32'd6200);
		push_sample(1'b1, 32'd6230);
		push_sample(1'b0, 32'd6300);
		push_sample(1'b0, 32'd6330);
		push_sample(1'b1, 32'd100);
		push_sample(1'b1, 32'd50);
		push_sample(1'b0, 32'hFFFF_FFFF);
		t_now = $urandom;
		add_random_samples(PHASE_ITEMS);
		wait_drained();

		for (ph = 0; ph < 7; ph++) begin
			apply_settings(deb_set[ph], hold_set[ph], win_set[ph], ph == 3 || ph == 6);
			send_idle_pct = send_set[ph];
			recv_stall_pct = recv_set[ph];
			if (ph == 3)
				squeeze = 1'b1;
			add_random_samples(PHASE_ITEMS);
			wait_drained();
		end

		$display("Sent %0d button samples over 8 register settings, zero and full-scale included.",
			samples_sent);
		$display("Gestures returned: none %0d, single tap %0d, double tap %0d, hold %0d.",
			gesture_seen[bgd_pkg::GEST_NONE], gesture_seen[bgd_pkg::GEST_TAP],
			gesture_seen[bgd_pkg::GEST_DOUBLE], gesture_seen[bgd_pkg::GEST_HOLD]);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("Timed out with %0d samples pending and %0d results outstanding.",
			pending_samples.size(), expected_gestures.size());
		$display("TEST FAILED");
		$finish;
	end

endmodule
